/* sv/tsu_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers of the translation skinning unit.
package tsu_pkg;

  localparam int MaxBones = 64;
  localparam int Lanes    = 4;
  localparam int IdxW     = $clog2(MaxBones);
  localparam int PosW     = 32;
  localparam int DeltaW   = PosW + 1;
  localparam int WeightW  = 16;
  localparam int BoneW    = 8;
  localparam int CountW   = 7;
  localparam int FracW    = 14;
  localparam int ProdW    = WeightW + DeltaW;
  localparam int TermW    = ProdW - FracW;
  localparam int AccW     = TermW + $clog2(Lanes) + 2;
  localparam int HalfLanes = Lanes / 2;

  localparam logic [1:0] ReqWrCur  = 2'd0;
  localparam logic [1:0] ReqWrBind = 2'd1;
  localparam logic [1:0] ReqSkin   = 2'd2;

  localparam logic signed [PosW-1:0] PosMaxS = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMinS = {1'b1, {(PosW-1){1'b0}}};

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] x;
    logic signed [DeltaW-1:0] y;
    logic signed [DeltaW-1:0] z;
  } delta_t;

  typedef struct packed {
    logic signed [TermW-1:0] x;
    logic signed [TermW-1:0] y;
    logic signed [TermW-1:0] z;
  } term_t;

  typedef struct packed {
    logic signed [AccW-1:0] x;
    logic signed [AccW-1:0] y;
    logic signed [AccW-1:0] z;
  } acc_t;

  typedef struct packed {
    logic            valid;
    logic            cur_sel;
    logic [IdxW-1:0] idx;
    pos_t            pos;
  } wr_req_t;

  typedef logic [Lanes-1:0][IdxW-1:0] idx_vec_t;
  typedef delta_t [Lanes-1:0] delta_vec_t;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(PosMaxS);
    lo = AccW'(PosMinS);
    if (v > hi) begin
      return PosMaxS;
    end else if (v < lo) begin
      return PosMinS;
    end
    return v[PosW-1:0];
  endfunction

endpackage

/* sv/tsu_req_if.sv */
`timescale 1ns / 1ps
// Request channel carrying bone position writes and skin items.
interface tsu_req_if;
  import tsu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [PosW-1:0]    pos_x;
  logic signed [PosW-1:0]    pos_y;
  logic signed [PosW-1:0]    pos_z;
  logic signed [BoneW-1:0]   bone0;
  logic signed [BoneW-1:0]   bone1;
  logic signed [BoneW-1:0]   bone2;
  logic signed [BoneW-1:0]   bone3;
  logic signed [WeightW-1:0] weight0;
  logic signed [WeightW-1:0] weight1;
  logic signed [WeightW-1:0] weight2;
  logic signed [WeightW-1:0] weight3;

  modport source (
    output valid, req_type, pos_x, pos_y, pos_z, bone0, bone1, bone2, bone3,
           weight0, weight1, weight2, weight3,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, pos_z, bone0, bone1, bone2, bone3,
           weight0, weight1, weight2, weight3,
    output ready
  );
endinterface

/* sv/tsu_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel carrying deformed vertex positions.
interface tsu_rsp_if;
  import tsu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] out_x;
  logic signed [PosW-1:0] out_y;
  logic signed [PosW-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

/* sv/tsu_bone_store.sv */
`timescale 1ns / 1ps
// Bone tables and per-lane delta memories with write forwarding.
module tsu_bone_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  tsu_pkg::wr_req_t    wr_req_i,
  input  tsu_pkg::idx_vec_t   rd_addr_i,
  output tsu_pkg::delta_vec_t delta_o
);
  import tsu_pkg::*;

  pos_t   cur_mem [MaxBones];
  pos_t   bnd_mem [MaxBones];
  delta_t dlt_mem [Lanes][MaxBones];

  logic [MaxBones-1:0] cur_vld_q;
  logic [MaxBones-1:0] bnd_vld_q;
  logic [MaxBones-1:0] dlt_vld_q;

  pos_t            cur_rd_q;
  pos_t            bnd_rd_q;
  logic            cur_hit_q;
  logic            bnd_hit_q;
  logic            w_vld_q;
  logic            w_cur_q;
  logic [IdxW-1:0] w_idx_q;
  pos_t            w_pos_q;
  pos_t            cur_v;
  pos_t            bnd_v;
  delta_t          w_delta;

  delta_t           lane_rd_q [Lanes];
  logic [Lanes-1:0] lane_vld_q;
  logic [Lanes-1:0] lane_fwd_q;
  delta_t           fwd_q;

  // The table of the written kind is updated at once; the other one is read
  // so that the new delta can be formed in the following cycle.
  always_ff @(posedge clk_i) begin
    if (wr_req_i.valid) begin
      if (wr_req_i.cur_sel) begin
        cur_mem[wr_req_i.idx] <= wr_req_i.pos;
      end else begin
        bnd_mem[wr_req_i.idx] <= wr_req_i.pos;
      end
      cur_rd_q  <= cur_mem[wr_req_i.idx];
      bnd_rd_q  <= bnd_mem[wr_req_i.idx];
      cur_hit_q <= cur_vld_q[wr_req_i.idx];
      bnd_hit_q <= bnd_vld_q[wr_req_i.idx];
      w_cur_q   <= wr_req_i.cur_sel;
      w_idx_q   <= wr_req_i.idx;
      w_pos_q   <= wr_req_i.pos;
    end
  end

  always_comb begin
    if (w_cur_q) begin
      cur_v = w_pos_q;
      bnd_v = bnd_hit_q ? bnd_rd_q : '0;
    end else begin
      cur_v = cur_hit_q ? cur_rd_q : '0;
      bnd_v = w_pos_q;
    end
    w_delta.x = DeltaW'(cur_v.x) - DeltaW'(bnd_v.x);
    w_delta.y = DeltaW'(cur_v.y) - DeltaW'(bnd_v.y);
    w_delta.z = DeltaW'(cur_v.z) - DeltaW'(bnd_v.z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= '0;
      bnd_vld_q  <= '0;
      dlt_vld_q  <= '0;
      w_vld_q    <= 1'b0;
      lane_fwd_q <= '0;
    end else begin
      if (wr_req_i.valid) begin
        if (wr_req_i.cur_sel) begin
          cur_vld_q[wr_req_i.idx] <= 1'b1;
        end else begin
          bnd_vld_q[wr_req_i.idx] <= 1'b1;
        end
      end
      if (advance_i) begin
        w_vld_q <= wr_req_i.valid;
        if (w_vld_q) begin
          dlt_vld_q[w_idx_q] <= 1'b1;
        end
        for (int l = 0; l < Lanes; l++) begin
          lane_fwd_q[l] <= w_vld_q && (w_idx_q == rd_addr_i[l]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int l = 0; l < Lanes; l++) begin
        if (w_vld_q) begin
          dlt_mem[l][w_idx_q] <= w_delta;
        end
        lane_rd_q[l]  <= dlt_mem[l][rd_addr_i[l]];
        lane_vld_q[l] <= dlt_vld_q[rd_addr_i[l]];
      end
      fwd_q <= w_delta;
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (lane_fwd_q[l]) begin
        delta_o[l] = fwd_q;
      end else if (lane_vld_q[l]) begin
        delta_o[l] = lane_rd_q[l];
      end else begin
        delta_o[l] = '0;
      end
    end
  end

endmodule

/* sv/translation_skinning_unit.sv */
`timescale 1ns / 1ps
// Translation-only vertex skinning with four influences per vertex.
// A skin item moves through stages s1, s2, s3 and then the output register.
// While ready is high, one item is accepted and one delta read per lane made per cycle.
// Request ready drops only while the output register and its skid stage are both full.
// Reset clears bone_count and the valid bits, so every bone table entry reads as zero.
// No clearing pass is needed, and items are accepted in the first cycle after reset.
module translation_skinning_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tsu_pkg::CountW-1:0] cfg_wdata_i,
  tsu_req_if.sink                    req_i,
  tsu_rsp_if.source                  rsp_o
);
  import tsu_pkg::*;

  logic [CountW-1:0] bone_count_q;
  logic              advance;
  logic              accept;
  logic [BoneW-1:0]  limit;

  logic signed [BoneW-1:0]   bone_in   [Lanes];
  logic signed [WeightW-1:0] weight_in [Lanes];
  logic [Lanes-1:0]          keep;

  idx_vec_t   rd_addr;
  wr_req_t    wr_req;
  delta_vec_t lane_delta;

  logic                      s1_vld_q;
  pos_t                      s1_rest_q;
  logic signed [WeightW-1:0] s1_w_q [Lanes];
  logic signed [ProdW-1:0]   prod_x [Lanes];
  logic signed [ProdW-1:0]   prod_y [Lanes];
  logic signed [ProdW-1:0]   prod_z [Lanes];
  term_t                     s1_term [Lanes];

  logic  s2_vld_q;
  pos_t  s2_rest_q;
  term_t s2_p_q [Lanes];
  acc_t  s2_a;
  acc_t  s2_b;

  logic s3_vld_q;
  pos_t s3_rest_q;
  acc_t s3_a_q;
  acc_t s3_b_q;
  acc_t tot;
  pos_t res;

  logic out_vld_q;
  logic skid_vld_q;
  pos_t out_q;
  pos_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_count_q <= '0;
    end else if (cfg_we_i) begin
      bone_count_q <= cfg_wdata_i;
    end
  end

  assign advance     = !skid_vld_q;
  assign req_i.ready = advance;
  assign accept      = req_i.valid && advance;

  always_comb begin
    bone_in[0]   = req_i.bone0;
    bone_in[1]   = req_i.bone1;
    bone_in[2]   = req_i.bone2;
    bone_in[3]   = req_i.bone3;
    weight_in[0] = req_i.weight0;
    weight_in[1] = req_i.weight1;
    weight_in[2] = req_i.weight2;
    weight_in[3] = req_i.weight3;
  end

  assign limit = (BoneW'(bone_count_q) > BoneW'(MaxBones)) ? BoneW'(MaxBones)
                                                           : BoneW'(bone_count_q);

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      keep[l] = !weight_in[l][WeightW-1] && (weight_in[l] != '0) &&
                !bone_in[l][BoneW-1] && ($unsigned(bone_in[l]) < limit);
      rd_addr[l] = bone_in[l][IdxW-1:0];
    end
  end

  always_comb begin
    wr_req.valid   = accept && ((req_i.req_type == ReqWrCur) || (req_i.req_type == ReqWrBind))
                     && !req_i.bone0[BoneW-1]
                     && ($unsigned(req_i.bone0) < BoneW'(MaxBones));
    wr_req.cur_sel = (req_i.req_type == ReqWrCur);
    wr_req.idx     = req_i.bone0[IdxW-1:0];
    wr_req.pos.x   = req_i.pos_x;
    wr_req.pos.y   = req_i.pos_y;
    wr_req.pos.z   = req_i.pos_z;
  end

  tsu_bone_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .wr_req_i  (wr_req),
    .rd_addr_i (rd_addr),
    .delta_o   (lane_delta)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= accept && (req_i.req_type == ReqSkin);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      prod_x[l]    = ProdW'(s1_w_q[l]) * ProdW'(lane_delta[l].x);
      prod_y[l]    = ProdW'(s1_w_q[l]) * ProdW'(lane_delta[l].y);
      prod_z[l]    = ProdW'(s1_w_q[l]) * ProdW'(lane_delta[l].z);
      s1_term[l].x = prod_x[l][ProdW-1:FracW];
      s1_term[l].y = prod_y[l][ProdW-1:FracW];
      s1_term[l].z = prod_z[l][ProdW-1:FracW];
    end
  end

  always_comb begin
    s2_a = '0;
    s2_b = '0;
    for (int l = 0; l < Lanes; l++) begin
      if (l < HalfLanes) begin
        s2_a.x = s2_a.x + AccW'(s2_p_q[l].x);
        s2_a.y = s2_a.y + AccW'(s2_p_q[l].y);
        s2_a.z = s2_a.z + AccW'(s2_p_q[l].z);
      end else begin
        s2_b.x = s2_b.x + AccW'(s2_p_q[l].x);
        s2_b.y = s2_b.y + AccW'(s2_p_q[l].y);
        s2_b.z = s2_b.z + AccW'(s2_p_q[l].z);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_rest_q.x <= req_i.pos_x;
      s1_rest_q.y <= req_i.pos_y;
      s1_rest_q.z <= req_i.pos_z;
      for (int l = 0; l < Lanes; l++) begin
        s1_w_q[l] <= keep[l] ? weight_in[l] : '0;
        s2_p_q[l] <= s1_term[l];
      end
      s2_rest_q <= s1_rest_q;
      s3_rest_q <= s2_rest_q;
      s3_a_q    <= s2_a;
      s3_b_q    <= s2_b;
    end
  end

  always_comb begin
    tot.x = AccW'(s3_rest_q.x) + s3_a_q.x + s3_b_q.x;
    tot.y = AccW'(s3_rest_q.y) + s3_a_q.y + s3_b_q.y;
    tot.z = AccW'(s3_rest_q.z) + s3_a_q.z + s3_b_q.z;
    res.x = sat_pos(tot.x);
    res.y = sat_pos(tot.y);
    res.z = sat_pos(tot.z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (rsp_o.ready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_vld_q && !rsp_o.ready) begin
      skid_vld_q <= s3_vld_q;
    end else begin
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (rsp_o.ready) begin
        out_q <= skid_q;
      end
    end else if (out_vld_q && !rsp_o.ready) begin
      skid_q <= res;
    end else begin
      out_q <= res;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.out_x = out_q.x;
  assign rsp_o.out_y = out_q.y;
  assign rsp_o.out_z = out_q.z;

endmodule

/* sv/tsu_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the translation skinning unit and their binding.
module tsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic [1:0] req_type_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i
);
  import tsu_pkg::*;

  logic skin_acc;

  assign skin_acc = req_valid_i && req_ready_i && (req_type_i == ReqSkin);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Response item dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> $past(rsp_valid_i && !rsp_ready_i))
    else $error("Request ready dropped without a stalled response.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(skin_acc, 4) && $past(req_ready_i, 1) && $past(req_ready_i, 2) &&
    $past(req_ready_i, 3) |-> rsp_valid_i)
    else $error("Skin item did not produce a response on time.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) && $past(req_ready_i, 1) && $past(req_ready_i, 2) &&
    $past(req_ready_i, 3) && $past(req_ready_i, 4) |-> $past(skin_acc, 4))
    else $error("Response appeared without a matching skin item.");

endmodule

bind translation_skinning_unit tsu_checker u_tsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready)
);
